[rtl/core/mtes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared types and constants for the MIDI track event serializer: beat
// structs for both channels, the job record passed from front to back and
// the status nibble codes.
// ----------------------------------------------------------------------------
package mtes_pkg;

  // Status nibble codes of channel events
  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_KEY_PRESS = 4'hA;
  localparam logic [3:0] KIND_CONTROL   = 4'hB;
  localparam logic [3:0] KIND_PROGRAM   = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
  localparam logic [3:0] KIND_PITCH     = 4'hE;

  // Number of data bytes per kind
  localparam logic [1:0] NDATA_NONE = 2'd0;
  localparam logic [1:0] NDATA_ONE  = 2'd1;
  localparam logic [1:0] NDATA_TWO  = 2'd2;

  // Delta time encoding
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned DELTA_BITS = 4 * GROUP_BITS;
  localparam logic        CONT_BIT   = 1'b1;

  // Position of a byte after the delta groups
  localparam logic [2:0] POS_STATUS = 3'd0;
  localparam logic [2:0] POS_DATA1  = 3'd1;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] event_tick;
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
  } event_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_event;
    logic       error_flag;
  } stream_t;

  // One classified event, ready to be serialized
  typedef struct packed {
    logic                  err;
    logic [DELTA_BITS-1:0] delta;
    logic [1:0]            groups_m1;
    logic [7:0]            status;
    logic [7:0]            data1;
    logic [7:0]            data2;
    logic                  two_data;
  } job_t;

  function automatic logic [1:0] data_count(input logic [3:0] kind);
    logic [1:0] cnt;
    case (kind)
      KIND_NOTE_OFF, KIND_NOTE_ON, KIND_KEY_PRESS, KIND_CONTROL, KIND_PITCH:
        cnt = NDATA_TWO;
      KIND_PROGRAM, KIND_CHAN_PRESS:
        cnt = NDATA_ONE;
      default:
        cnt = NDATA_NONE;
    endcase
    return cnt;
  endfunction

endpackage

[rtl/core/mtes_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_front
// Accepts events, forms the delta against the previous tick, classifies
// the kind and pushes one job per event into the queue.
// ----------------------------------------------------------------------------
module mtes_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             event_valid,
  output logic             event_stall,
  input  mtes_pkg::event_t event_beat,
  input  logic             queue_full,
  output logic             push,
  output mtes_pkg::job_t   push_job
);
  import mtes_pkg::*;

  logic [31:0] prev_tick;
  logic [31:0] delta;
  logic [1:0]  ndata;
  logic        too_big;
  logic        err;

  assign event_stall = queue_full;
  assign push        = event_valid && !queue_full;

  // Delta and classification
  always_comb begin
    delta   = event_beat.event_tick - prev_tick;
    ndata   = data_count(event_beat.event_kind);
    too_big = |delta[31:DELTA_BITS];
    err     = too_big || (ndata == NDATA_NONE);

    push_job.err      = err;
    push_job.delta    = delta[DELTA_BITS-1:0];
    push_job.status   = {event_beat.event_kind, event_beat.channel};
    push_job.data1    = event_beat.first_data;
    push_job.data2    = event_beat.second_data;
    push_job.two_data = (ndata == NDATA_TWO);
    if (|delta[4*GROUP_BITS-1:3*GROUP_BITS]) begin
      push_job.groups_m1 = 2'd3;
    end else if (|delta[3*GROUP_BITS-1:2*GROUP_BITS]) begin
      push_job.groups_m1 = 2'd2;
    end else if (|delta[2*GROUP_BITS-1:GROUP_BITS]) begin
      push_job.groups_m1 = 2'd1;
    end else begin
      push_job.groups_m1 = 2'd0;
    end
  end

  // Previous tick moves only on a good event
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tick <= '0;
    end else if (push && !err) begin
      prev_tick <= event_beat.event_tick;
    end
  end

endmodule

[rtl/core/mtes_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_queue
// Short job queue between front and back; the head is read in place.
// ----------------------------------------------------------------------------
module mtes_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtes_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output mtes_pkg::job_t head_job
);
  import mtes_pkg::*;

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/core/mtes_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_back
// Walks the head job into the output register and pops it with its last byte:
// delta groups, status, one or two data bytes; or one zero byte on error.
// ----------------------------------------------------------------------------
module mtes_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  mtes_pkg::job_t    head_job,
  output logic              pop,
  output logic              stream_valid,
  input  logic              stream_stall,
  output mtes_pkg::stream_t stream_beat
);
  import mtes_pkg::*;

  logic [2:0]            step;
  logic [2:0]            gm1_ext;
  logic [2:0]            rel;
  logic [2:0]            last_idx;
  logic [1:0]            grp_sel;
  logic [GROUP_BITS-1:0] grp;
  logic                  load;
  stream_t               cur;

  assign load = head_valid && (!stream_valid || !stream_stall);
  assign pop  = load && cur.last_of_event;

  // Byte for the current step
  always_comb begin
    gm1_ext  = {1'b0, head_job.groups_m1};
    rel      = step - gm1_ext - 3'd1;
    last_idx = gm1_ext + 3'd2 + {2'b00, head_job.two_data};
    grp_sel  = head_job.groups_m1 - step[1:0];
    case (grp_sel)
      2'd0:    grp = head_job.delta[GROUP_BITS-1:0];
      2'd1:    grp = head_job.delta[2*GROUP_BITS-1:GROUP_BITS];
      2'd2:    grp = head_job.delta[3*GROUP_BITS-1:2*GROUP_BITS];
      default: grp = head_job.delta[4*GROUP_BITS-1:3*GROUP_BITS];
    endcase

    cur.error_flag    = head_job.err;
    cur.last_of_event = head_job.err || (step == last_idx);
    if (head_job.err) begin
      cur.out_byte = '0;
    end else if (step <= gm1_ext) begin
      // upper groups carry the continuation bit
      cur.out_byte = {(grp_sel != 2'd0) & CONT_BIT, grp};
    end else begin
      case (rel)
        POS_STATUS: cur.out_byte = head_job.status;
        POS_DATA1:  cur.out_byte = head_job.data1;
        default:    cur.out_byte = head_job.data2;
      endcase
    end
  end

  // Step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      stream_valid <= 1'b0;
    end else begin
      if (load) begin
        stream_valid <= 1'b1;
        step         <= cur.last_of_event ? 3'd0 : step + 3'd1;
      end else if (!stream_stall) begin
        stream_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      stream_beat <= cur;
    end
  end

endmodule

[rtl/core/midi_track_event_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_serializer
// Turns channel events into standard MIDI file track bytes: a delta-time
// variable-length quantity, the status byte and the data bytes.
//
//   channel   handshake                beat         contents
//   event     event_valid/event_stall  event_beat   tick, kind, channel, data
//   stream    stream_valid/stream_stall stream_beat  byte, last, error
//
// An event gives 3 to 7 bytes (one on error); the output port moves one
// byte per cycle while stream_stall is low.
// Each event is written into the job queue, then its first byte into the output register.
// A two-entry job queue lets new events enter while bytes still drain.
// Reset clears the previous tick to zero and empties queue and output.
// A stalled stream holds its byte; the queue stalls events when full.
// ----------------------------------------------------------------------------
module midi_track_event_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  output logic              event_stall,
  input  mtes_pkg::event_t  event_beat,
  output logic              stream_valid,
  input  logic              stream_stall,
  output mtes_pkg::stream_t stream_beat
);
  import mtes_pkg::*;

  logic queue_full;
  logic push;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  mtes_front u_front (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_beat  (event_beat),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  mtes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mtes_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_beat  (stream_beat)
  );

endmodule

[rtl/core/mtes_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtes_checker
// Port-level checks on the serializer, bound to the top level.
// ----------------------------------------------------------------------------
module mtes_checker (
  input logic              clk,
  input logic              rst,
  input logic              stream_valid,
  input logic              stream_stall,
  input mtes_pkg::stream_t stream_beat
);
  import mtes_pkg::*;

  // stalled beat stays valid
  assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_stall |=> stream_valid)
    else $error("stream beat dropped under stall");

  // stalled beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_stall |=> $stable(stream_beat))
    else $error("stream beat changed under stall");

  // error beats close their event
  assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_beat.error_flag |-> stream_beat.last_of_event)
    else $error("error beat not marked last");

  // error beats carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    stream_valid && stream_beat.error_flag |-> stream_beat.out_byte == 8'h00)
    else $error("error beat with nonzero byte");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !stream_valid)
    else $error("stream valid after reset");

endmodule

bind midi_track_event_serializer mtes_checker u_mtes_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIDI track event serializer. A queue of
// channel events (a directed opening, then random events that are mostly
// well formed) feeds a bursty driver. A predictor turns every accepted
// event into its delta-time, status and data bytes. The monitor checks the
// byte stream in order against them while the receiver stalls on its own
// pattern and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;
  import mtes_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_EVENTS   = 430;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_START_EVT  = 120;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 10;

  localparam logic [31:0] VLQ_MAX    = 32'h0FFF_FFFF;
  localparam logic [7:0]  GROUP_MASK = 8'h7F;
  localparam logic [7:0]  CONT_MASK  = 8'h80;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      event_valid  = 1'b0;
  logic      event_stall;
  event_t    event_beat   = '0;
  logic      stream_valid;
  logic      stream_stall;
  stream_t   stream_beat;

  logic      pattern_stall  = 1'b0;
  logic      holdoff_active = 1'b0;

  event_t    pending_events[$];
  stream_t   expected_bytes[$];

  logic [31:0] track_tick = '0;  // predictor copy of the previous tick
  logic [31:0] gen_tick   = '0;  // generator copy, used to pick ticks
  logic        last_accept = 1'b0;
  logic [15:0] kinds_seen  = '0;

  int events_accepted = 0;
  int events_rejected = 0;
  int bytes_checked   = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int hold_stall_cycles = 0;

  midi_track_event_serializer u_dut (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_beat   (event_beat),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_beat  (stream_beat)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  assign stream_stall = pattern_stall | holdoff_active;

  // Expected track bytes for one event; advances the tick on success
  function automatic void serialize_event(input event_t ev);
    logic [31:0] delta;
    logic [1:0]  ndata;
    int          groups;
    logic [7:0]  grp;
    delta = ev.event_tick - track_tick;
    case (ev.event_kind)
      KIND_NOTE_OFF, KIND_NOTE_ON, KIND_KEY_PRESS, KIND_CONTROL, KIND_PITCH:
        ndata = NDATA_TWO;
      KIND_PROGRAM, KIND_CHAN_PRESS:
        ndata = NDATA_ONE;
      default:
        ndata = NDATA_NONE;
    endcase
    if (ndata == NDATA_NONE || delta > VLQ_MAX) begin
      expected_bytes.push_back('{out_byte: 8'h00, last_of_event: 1'b1, error_flag: 1'b1});
      events_rejected++;
      return;
    end
    if (delta < 32'h0000_0080) groups = 1;
    else if (delta < 32'h0000_4000) groups = 2;
    else if (delta < 32'h0020_0000) groups = 3;
    else groups = 4;
    // delta groups, most significant first, continuation on all but last
    for (int g = groups - 1; g >= 0; g--) begin
      grp = 8'(delta >> (7 * g)) & GROUP_MASK;
      if (g != 0) grp = grp | CONT_MASK;
      expected_bytes.push_back('{out_byte: grp, last_of_event: 1'b0, error_flag: 1'b0});
    end
    expected_bytes.push_back('{out_byte: {ev.event_kind, ev.channel},
                               last_of_event: 1'b0, error_flag: 1'b0});
    expected_bytes.push_back('{out_byte: ev.first_data,
                               last_of_event: (ndata == NDATA_ONE), error_flag: 1'b0});
    if (ndata == NDATA_TWO)
      expected_bytes.push_back('{out_byte: ev.second_data,
                                 last_of_event: 1'b1, error_flag: 1'b0});
    track_tick = ev.event_tick;
  endfunction

  // Queue an event and follow the tick the block will hold afterwards
  task automatic queue_event(input logic [31:0] tick, input logic [3:0] kind,
                             input logic [3:0] chan, input logic [7:0] d1,
                             input logic [7:0] d2);
    pending_events.push_back('{event_tick: tick, event_kind: kind, channel: chan,
                               first_data: d1, second_data: d2});
    if (kind >= KIND_NOTE_OFF && kind <= KIND_PITCH && (tick - gen_tick) <= VLQ_MAX)
      gen_tick = tick;
  endtask

  task automatic note_mismatch(input string what, input stream_t want, input stream_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s at byte %0d: expected %02h last %0b err %0b, got %02h last %0b err %0b",
               what, bytes_checked, want.out_byte, want.last_of_event, want.error_flag,
               got.out_byte, got.last_of_event, got.error_flag);
  endtask

  // Event acceptance: predict on every accepted beat
  always @(posedge clk) begin : accept_events
    last_accept = !rst && event_valid && !event_stall;
    if (last_accept) begin
      serialize_event(event_beat);
      kinds_seen[event_beat.event_kind] = 1'b1;
      void'(pending_events.pop_front());
      events_accepted++;
    end
  end

  // Event driver: bursts of beats with random gaps, payload held while stalled
  always @(negedge clk) begin : drive_events
    int     burst_left;
    int     gap_left;
    logic   next_valid;
    event_t next_beat;
    next_valid = event_valid;
    next_beat  = event_beat;
    if (rst) begin
      next_valid = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!event_valid || last_accept) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_events.size() > 0) begin
        next_valid = 1'b1;
        next_beat  = pending_events[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 10);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    event_valid <= next_valid;
    event_beat  <= next_beat;
  end

  // Receiver stall pattern, switching among the modes at random
  always @(negedge clk) begin : stall_pattern
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    if (rst) begin
      mode      = RX_FREE;
      mode_left = 0;
      phase     = 0;
      pattern_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      phase++;
      case (mode)
        RX_FREE:     pattern_stall <= 1'b0;
        RX_LIGHT:    pattern_stall <= ($urandom_range(0, 99) < 25);
        RX_PERIODIC: pattern_stall <= (phase % 4 == 3);
        default:     pattern_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // One long receiver hold-off in mid run so the block backs up
  always @(negedge clk) begin : long_holdoff
    int   hold_left;
    logic hold_done;
    if (rst) begin
      hold_left = 0;
      hold_done = 1'b0;
      holdoff_active <= 1'b0;
    end else if (!hold_done && events_accepted >= HOLD_START_EVT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      holdoff_active <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      if (event_stall) hold_stall_cycles++;
      if (hold_left == 0) holdoff_active <= 1'b0;
    end
  end

  // Stream monitor: every byte against the oldest expectation
  always @(posedge clk) begin : check_stream
    stream_t want;
    if (!rst && stream_valid && !stream_stall) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("unexpected beat", '0, stream_beat);
      end else begin
        want = expected_bytes.pop_front();
        if (stream_beat.out_byte != want.out_byte ||
            stream_beat.last_of_event != want.last_of_event ||
            stream_beat.error_flag != want.error_flag)
          note_mismatch("wrong beat", want, stream_beat);
      end
      bytes_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events pending, %0d bytes expected",
               cycle_count, pending_events.size(), expected_bytes.size());
      $display("midi_track_event_serializer: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] delta;
    logic [31:0] tick;
    logic [3:0]  kind;
    int          roll;

    // Directed: delta boundaries, each kind, rejects and same-tick events
    queue_event(32'h0000_0000, KIND_NOTE_ON, 4'h0, 8'h00, 8'h00);
    queue_event(32'h0000_007F, KIND_NOTE_OFF, 4'hF, 8'hFF, 8'hFF);
    queue_event(gen_tick + 32'h80, KIND_KEY_PRESS, 4'h5, 8'h3C, 8'h40);
    queue_event(gen_tick + 32'h3FFF, KIND_CONTROL, 4'hA, 8'h07, 8'h7F);
    queue_event(gen_tick + 32'h4000, KIND_PROGRAM, 4'h3, 8'h55, 8'hAA);
    queue_event(gen_tick + 32'h1F_FFFF, KIND_CHAN_PRESS, 4'hC, 8'h80, 8'h11);
    queue_event(gen_tick + 32'h20_0000, KIND_PITCH, 4'h9, 8'h00, 8'h40);
    queue_event(gen_tick + VLQ_MAX, KIND_NOTE_ON, 4'h1, 8'h60, 8'h01);
    queue_event(gen_tick + VLQ_MAX + 1, KIND_NOTE_ON, 4'h2, 8'h61, 8'h02);
    queue_event(gen_tick - 1, KIND_NOTE_OFF, 4'h4, 8'h62, 8'h03);
    queue_event(gen_tick, KIND_CONTROL, 4'h6, 8'h40, 8'h00);
    for (int k = 0; k < 9; k++) begin
      kind = (k == 8) ? 4'hF : 4'(k);
      queue_event(gen_tick + 5, kind, 4'(k), 8'(k * 29), 8'(k * 31));
    end
    queue_event(gen_tick + 1, KIND_PROGRAM, 4'h7, 8'h7F, 8'hFF);

    // Random: mostly well-formed events across all delta sizes
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      roll = $urandom_range(0, 99);
      kind = 4'(KIND_NOTE_OFF + $urandom_range(0, 6));
      if (roll < 12)      delta = 32'h0;
      else if (roll < 40) delta = $urandom_range(32'h7F, 32'h1);
      else if (roll < 60) delta = $urandom_range(32'h3FFF, 32'h80);
      else if (roll < 75) delta = $urandom_range(32'h1F_FFFF, 32'h4000);
      else if (roll < 90) delta = ($urandom_range(0, 3) == 0) ? VLQ_MAX
                                  : $urandom_range(VLQ_MAX, 32'h20_0000);
      else if (roll < 94) delta = $urandom_range(32'hFFFF_FFFF, VLQ_MAX + 1);
      else if (roll < 97) delta = -$urandom_range(1000, 1);
      else begin
        delta = $urandom_range(32'h3FFF, 32'h0);
        roll  = $urandom_range(0, 8);
        kind  = (roll == 8) ? 4'hF : 4'(roll);
      end
      tick = gen_tick + delta;
      queue_event(tick, kind, 4'($urandom), 8'($urandom), 8'($urandom));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d events (%0d rejected, %0d of 16 kinds), %0d bytes checked",
             events_accepted, events_rejected, $countones(kinds_seen), bytes_checked);
    $display("receiver held off %0d cycles; event input stalled %0d of them",
             HOLD_CYCLES, hold_stall_cycles);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("midi_track_event_serializer: match");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", mismatches, expected_bytes.size());
      $display("midi_track_event_serializer: mismatch");
    end
    $finish;
  end

endmodule
